@@ sv/ndft_pkg.sv @@
`default_nettype none
package ndft_pkg;

  // Sample store geometry.
  localparam int unsigned SAMPLE_AW = 10;
  localparam int unsigned MAX_SAMPLES = 1 << SAMPLE_AW;
  localparam int unsigned CNT_W = SAMPLE_AW + 1;

  // Field and datapath widths.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned VAL_W = 16;
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned SUM_W = VAL_W + SAMPLE_AW + 1;
  localparam int unsigned D_W = VAL_W + 2;
  localparam int unsigned TRIG_W = 16;
  localparam int unsigned PROD_W = D_W + TRIG_W;
  localparam int unsigned ACC_W = 2 * VAL_W + SAMPLE_AW + 1;
  localparam int unsigned SQ_W = 2 * ACC_W;
  localparam int unsigned MAG_W = 42;

  // Cosine/sine table.
  localparam int unsigned TRIG_BITS = 10;
  localparam int unsigned TRIG_N = 1 << TRIG_BITS;
  localparam logic [63:0] PIO2_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef logic [2*TRIG_W-1:0] trig_rom_t [TRIG_N];

  // Input item modes.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_STOP = 2'd1;
  localparam logic [1:0] REG_STEP = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] start;
    logic [FREQ_W-1:0] stop;
    logic [FREQ_W-1:0] step;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear;
    logic div_start;
    logic mac_start;
    logic sq_start;
    logic root_start;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic div_done;
    logic mac_done;
    logic sq_done;
    logic root_done;
  } sts_t;

  // Clamp a Q30 value to [0, 1] and round it to Q15.
  function automatic logic [TRIG_W-1:0] q30_to_q15(longint v);
    longint w;
    longint u;
    w = v;
    if (w < 0) w = 0;
    if (w > longint'(ONE_Q30)) w = longint'(ONE_Q30);
    u = (w + 16384) >>> 15;
    if (u > 32767) u = 32767;
    return u[TRIG_W-1:0];
  endfunction

  // One table entry: cosine in the upper half, sine in the lower half.
  function automatic logic [2*TRIG_W-1:0] trig_entry(int unsigned k);
    logic [31:0] a;
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint ss;
    longint cs;
    logic [TRIG_W-1:0] s;
    logic [TRIG_W-1:0] c;
    logic [2*TRIG_W-1:0] res;
    a = 32'(k) << (32 - TRIG_BITS);
    theta = ({34'd0, a[29:0]} * PIO2_Q30) >> 30;
    t2 = (theta * theta) >> 30;
    ts = theta;
    tc = ONE_Q30;
    ss = longint'(theta);
    cs = longint'(ONE_Q30);
    for (int unsigned j = 1; j <= 8; j++) begin
      ts = ((ts * t2) >> 30) / 64'((2 * j) * (2 * j + 1));
      tc = ((tc * t2) >> 30) / 64'((2 * j - 1) * (2 * j));
      if (j[0]) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    s = q30_to_q15(ss);
    c = q30_to_q15(cs);
    case (a[31:30])
      2'd0: res = {c, s};
      2'd1: res = {-s, c};
      2'd2: res = {-c, -s};
      default: res = {s, -c};
    endcase
    return res;
  endfunction

  function automatic trig_rom_t build_trig();
    trig_rom_t t;
    for (int unsigned k = 0; k < TRIG_N; k++) begin
      t[k] = trig_entry(k);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ sv/ndft_dp.sv @@
`default_nettype none
module ndft_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ndft_pkg::cmd_t                      cmd_i,
  output ndft_pkg::sts_t                           sts_o,
  input  wire logic signed [ndft_pkg::TIME_W-1:0]  sample_time_i,
  input  wire logic signed [ndft_pkg::VAL_W-1:0]   sample_value_i,
  input  wire logic [ndft_pkg::FREQ_W-1:0]         freq_i,
  output logic [ndft_pkg::MAG_W-1:0]               magnitude_o
);

  localparam int unsigned AW = ndft_pkg::SAMPLE_AW;
  localparam int unsigned CW = ndft_pkg::CNT_W;
  localparam int unsigned SW = ndft_pkg::SUM_W;
  localparam int unsigned DW = ndft_pkg::D_W;
  localparam int unsigned TW = ndft_pkg::TRIG_W;
  localparam int unsigned PW = ndft_pkg::PROD_W;
  localparam int unsigned AC = ndft_pkg::ACC_W;
  localparam int unsigned QW = ndft_pkg::SQ_W;
  localparam int unsigned RW = AC + 3;
  localparam int unsigned TB = ndft_pkg::TRIG_BITS;
  localparam int unsigned DIV_CW = $clog2(SW);
  localparam int unsigned AC_CW = $clog2(AC);
  localparam ndft_pkg::trig_rom_t TrigRom = ndft_pkg::build_trig();

  // Sample store and running totals.
  logic [ndft_pkg::TIME_W-1:0] time_mem [ndft_pkg::MAX_SAMPLES];
  logic [ndft_pkg::VAL_W-1:0]  val_mem [ndft_pkg::MAX_SAMPLES];
  logic [CW-1:0]               count_q, count_d;
  logic signed [SW-1:0]        sum_q, sum_d;
  logic                        wr_en;

  assign wr_en = cmd_i.load && (count_q < CW'(ndft_pkg::MAX_SAMPLES));

  always_comb begin
    count_d = count_q;
    sum_d = sum_q;
    if (cmd_i.clear) begin
      count_d = '0;
      sum_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CW'(1);
      sum_d = sum_q + SW'(sample_value_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q <= '0;
    end else begin
      count_q <= count_d;
      sum_q <= sum_d;
    end
  end

  // Store writes.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      time_mem[count_q[AW-1:0]] <= sample_time_i;
      val_mem[count_q[AW-1:0]] <= sample_value_i;
    end
  end

  // Restoring divider for the mean, one quotient bit per cycle.
  logic [SW-1:0]     dq_q, dq_d;
  logic [CW-1:0]     rem_q, rem_d;
  logic [CW:0]       rem_t;
  logic              div_ge;
  logic              div_busy_q, div_busy_d;
  logic [DIV_CW-1:0] div_cnt_q, div_cnt_d;
  logic              neg_q, neg_d;
  logic              div_done;
  logic [SW-1:0]     mean;

  assign rem_t = {rem_q, dq_q[SW-1]};
  assign div_ge = rem_t >= {1'b0, count_q};
  assign div_done = div_busy_q && (div_cnt_q == DIV_CW'(SW - 1));
  assign mean = neg_q ? (SW'(0) - dq_q) : dq_q;

  always_comb begin
    dq_d = dq_q;
    rem_d = rem_q;
    div_busy_d = div_busy_q;
    div_cnt_d = div_cnt_q;
    neg_d = neg_q;
    if (cmd_i.div_start) begin
      neg_d = sum_q[SW-1];
      dq_d = sum_q[SW-1] ? (SW'(0) - SW'(sum_q)) : SW'(sum_q);
      rem_d = '0;
      div_busy_d = 1'b1;
      div_cnt_d = '0;
    end else if (div_busy_q) begin
      rem_d = div_ge ? CW'(rem_t - {1'b0, count_q}) : CW'(rem_t);
      dq_d = {dq_q[SW-2:0], div_ge};
      div_cnt_d = div_cnt_q + DIV_CW'(1);
      if (div_done) div_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      div_busy_q <= div_busy_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q <= dq_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  // Multiply-accumulate pipeline over the stored samples.
  logic [CW-1:0]               k_q, k_d;
  logic                        issue_q, issue_d;
  logic                        mac_busy_q, mac_busy_d;
  logic                        p1_q, p2_q, p3_q, p4_q;
  logic [ndft_pkg::TIME_W-1:0] t1_q;
  logic [ndft_pkg::VAL_W-1:0]  v1_q;
  logic [31:0]                 frac2_q;
  logic signed [DW-1:0]        d2_q, d3_q;
  logic [2*TW-1:0]             trig3_q;
  logic signed [PW-1:0]        prc4_q, prs4_q;
  logic signed [AC-1:0]        re_q, re_d, im_q, im_d;
  logic [SW:0]                 d_full;
  logic                        mac_done;

  assign d_full = (SW + 1)'(signed'(v1_q)) - {mean[SW-1], mean};
  assign mac_done = mac_busy_q && !issue_q && !p1_q && !p2_q && !p3_q && !p4_q;

  always_comb begin
    k_d = k_q;
    issue_d = issue_q;
    mac_busy_d = mac_busy_q;
    re_d = re_q;
    im_d = im_q;
    if (cmd_i.mac_start) begin
      k_d = '0;
      issue_d = 1'b1;
      mac_busy_d = 1'b1;
      re_d = '0;
      im_d = '0;
    end else begin
      if (issue_q) begin
        k_d = k_q + CW'(1);
        if (k_d == count_q) issue_d = 1'b0;
      end
      if (p4_q) begin
        re_d = re_q + AC'(prc4_q);
        im_d = im_q - AC'(prs4_q);
      end
      if (mac_done) mac_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      issue_q <= 1'b0;
      mac_busy_q <= 1'b0;
      p1_q <= 1'b0;
      p2_q <= 1'b0;
      p3_q <= 1'b0;
      p4_q <= 1'b0;
    end else begin
      k_q <= k_d;
      issue_q <= issue_d;
      mac_busy_q <= mac_busy_d;
      p1_q <= issue_q;
      p2_q <= p1_q;
      p3_q <= p2_q;
      p4_q <= p3_q;
    end
  end

  // Pipeline payload: store read, phase product, table read, products.
  always_ff @(posedge clk_i) begin
    t1_q <= time_mem[k_q[AW-1:0]];
    v1_q <= val_mem[k_q[AW-1:0]];
    frac2_q <= 32'(freq_i * t1_q);
    d2_q <= DW'(d_full);
    d3_q <= d2_q;
    trig3_q <= TrigRom[frac2_q[31 -: TB]];
    prc4_q <= PW'(d3_q * signed'(trig3_q[2*TW-1:TW]));
    prs4_q <= PW'(d3_q * signed'(trig3_q[TW-1:0]));
    re_q <= re_d;
    im_q <= im_d;
  end

  // Shift-and-add squarer: re squared, then im squared, into one sum.
  logic [AC-1:0]    abs_re, abs_im;
  logic [AC-1:0]    opnd_q, opnd_d;
  logic [QW-1:0]    mc_q, mc_d;
  logic [QW-1:0]    sq_q, sq_d;
  logic             sq_busy_q, sq_busy_d;
  logic             sq_ph_q, sq_ph_d;
  logic [AC_CW-1:0] sq_cnt_q, sq_cnt_d;
  logic             sq_done;

  assign abs_re = re_q[AC-1] ? (AC'(0) - AC'(re_q)) : AC'(re_q);
  assign abs_im = im_q[AC-1] ? (AC'(0) - AC'(im_q)) : AC'(im_q);
  assign sq_done = sq_busy_q && sq_ph_q && (sq_cnt_q == AC_CW'(AC - 1));

  always_comb begin
    opnd_d = opnd_q;
    mc_d = mc_q;
    sq_d = sq_q;
    sq_busy_d = sq_busy_q;
    sq_ph_d = sq_ph_q;
    sq_cnt_d = sq_cnt_q;
    if (cmd_i.sq_start) begin
      opnd_d = abs_re;
      mc_d = QW'(abs_re);
      sq_d = '0;
      sq_busy_d = 1'b1;
      sq_ph_d = 1'b0;
      sq_cnt_d = '0;
    end else if (sq_busy_q) begin
      if (opnd_q[0]) sq_d = sq_q + mc_q;
      opnd_d = opnd_q >> 1;
      mc_d = mc_q << 1;
      sq_cnt_d = sq_cnt_q + AC_CW'(1);
      if (sq_cnt_q == AC_CW'(AC - 1)) begin
        sq_cnt_d = '0;
        if (sq_ph_q) begin
          sq_busy_d = 1'b0;
        end else begin
          sq_ph_d = 1'b1;
          opnd_d = abs_im;
          mc_d = QW'(abs_im);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_ph_q <= 1'b0;
      sq_cnt_q <= '0;
    end else begin
      sq_busy_q <= sq_busy_d;
      sq_ph_q <= sq_ph_d;
      sq_cnt_q <= sq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opnd_q <= opnd_d;
    mc_q <= mc_d;
    sq_q <= sq_d;
  end

  // Digit-by-digit square root, two radicand bits per cycle.
  logic [QW-1:0]    rad_q, rad_d;
  logic [RW-1:0]    rrem_q, rrem_d;
  logic [RW-1:0]    rrem_t, trial;
  logic [AC-1:0]    root_q, root_d;
  logic             rt_busy_q, rt_busy_d;
  logic [AC_CW-1:0] rt_cnt_q, rt_cnt_d;
  logic             root_done;
  logic             rt_ge;

  assign rrem_t = {rrem_q[RW-3:0], rad_q[QW-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign rt_ge = rrem_t >= trial;
  assign root_done = rt_busy_q && (rt_cnt_q == AC_CW'(AC - 1));

  always_comb begin
    rad_d = rad_q;
    rrem_d = rrem_q;
    root_d = root_q;
    rt_busy_d = rt_busy_q;
    rt_cnt_d = rt_cnt_q;
    if (cmd_i.root_start) begin
      rad_d = sq_q;
      rrem_d = '0;
      root_d = '0;
      rt_busy_d = 1'b1;
      rt_cnt_d = '0;
    end else if (rt_busy_q) begin
      rad_d = rad_q << 2;
      rrem_d = rt_ge ? (rrem_t - trial) : rrem_t;
      root_d = {root_q[AC-2:0], rt_ge};
      rt_cnt_d = rt_cnt_q + AC_CW'(1);
      if (root_done) rt_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_busy_q <= 1'b0;
      rt_cnt_q <= '0;
    end else begin
      rt_busy_q <= rt_busy_d;
      rt_cnt_q <= rt_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    rrem_q <= rrem_d;
    root_q <= root_d;
  end

  // Saturate the root to the magnitude width.
  assign magnitude_o = (root_q[AC-1:ndft_pkg::MAG_W] != '0) ? '1 : root_q[ndft_pkg::MAG_W-1:0];

  always_comb begin
    sts_o.empty = (count_q == '0);
    sts_o.div_done = div_done;
    sts_o.mac_done = mac_done;
    sts_o.sq_done = sq_done;
    sts_o.root_done = root_done;
  end

endmodule
`default_nettype wire

@@ sv/ndft_ctrl.sv @@
`default_nettype none
module ndft_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ndft_pkg::cfg_t                cfg_i,
  input  wire logic                          cfg_wr_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  output ndft_pkg::cmd_t                     cmd_o,
  input  wire ndft_pkg::sts_t                sts_i,
  output logic [ndft_pkg::FREQ_W-1:0]        freq_o,
  input  wire logic [ndft_pkg::MAG_W-1:0]    mag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ndft_pkg::FREQ_W-1:0]        frequency_o,
  output logic [ndft_pkg::MAG_W-1:0]         magnitude_o,
  output logic                               is_last_o,
  output logic                               status_o
);

  localparam int unsigned FW = ndft_pkg::FREQ_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MAC  = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e          state_q, state_d;
  logic [FW:0]     cur_q, cur_d;
  logic            fresh_q, fresh_d;
  logic [FW:0]     next_q, next_d;
  logic            last_q, last_d;
  logic            err_q, err_d;
  logic [FW-1:0]   freq_q, freq_d;
  logic            ov_q, ov_d;
  logic [FW-1:0]   ofreq_q, ofreq_d;
  logic [ndft_pkg::MAG_W-1:0] omag_q, omag_d;
  logic            olast_q, olast_d;
  logic            ostat_q, ostat_d;
  logic            accept;
  logic [FW:0]     cur_eff;
  logic [FW:0]     nxt;
  logic            out_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign cur_eff = fresh_q ? {1'b0, cfg_i.start} : cur_q;
  assign nxt = cur_eff + {1'b0, cfg_i.step};
  assign out_free = !ov_q || !out_stall_i;
  assign freq_o = freq_q;

  // Sequencer and sweep bookkeeping.
  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    fresh_d = fresh_q;
    next_d = next_q;
    last_d = last_q;
    err_d = err_q;
    freq_d = freq_q;
    ov_d = ov_q && out_stall_i;
    ofreq_d = ofreq_q;
    omag_d = omag_q;
    olast_d = olast_q;
    ostat_d = ostat_q;
    cmd_o = '0;
    if (cfg_wr_i) fresh_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_i)
            ndft_pkg::MODE_LOAD: cmd_o.load = 1'b1;
            ndft_pkg::MODE_CLEAR: begin
              cmd_o.clear = 1'b1;
              fresh_d = 1'b1;
            end
            ndft_pkg::MODE_COMPUTE: begin
              if (cur_eff > {1'b0, cfg_i.stop}) begin
                fresh_d = 1'b1;
              end else begin
                freq_d = cur_eff[FW-1:0];
                next_d = nxt;
                last_d = nxt > {1'b0, cfg_i.stop};
                err_d = sts_i.empty;
                if (sts_i.empty) begin
                  state_d = ST_OUT;
                end else begin
                  cmd_o.div_start = 1'b1;
                  state_d = ST_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.mac_start = 1'b1;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (sts_i.mac_done) begin
          cmd_o.sq_start = 1'b1;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (sts_i.sq_done) begin
          cmd_o.root_start = 1'b1;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sts_i.root_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          ov_d = 1'b1;
          ofreq_d = freq_q;
          omag_d = err_q ? '0 : mag_i;
          olast_d = last_q;
          ostat_d = err_q;
          if (last_q) begin
            fresh_d = 1'b1;
          end else begin
            cur_d = next_q;
            fresh_d = 1'b0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q <= '0;
      fresh_q <= 1'b1;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q <= cur_d;
      fresh_q <= fresh_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q <= next_d;
    last_q <= last_d;
    err_q <= err_d;
    freq_q <= freq_d;
    ofreq_q <= ofreq_d;
    omag_q <= omag_d;
    olast_q <= olast_d;
    ostat_q <= ostat_d;
  end

  assign out_valid_o = ov_q;
  assign frequency_o = ofreq_q;
  assign magnitude_o = omag_q;
  assign is_last_o = olast_q;
  assign status_o = ostat_q;

endmodule
`default_nettype wire

@@ sv/nonuniform_dft_magnitude_sweep.sv @@
// Nonuniform DFT magnitude sweep.
// Input channel (in_valid_i / in_stall_o) carries one transaction per item:
// mode_i selects load sample, compute next frequency point, or clear.
// Loads, clears and unused modes give no result.
// A compute walks every stored sample with one multiply-accumulate per cycle.
// It runs the mean divider, the accumulate pipeline, the serial squarer and
// the square-root unit in turn, then registers the result; with no samples
// it goes straight to the result.
// The input is stalled while a compute is in progress, one item at a time.
// Results leave through a register on the output channel (out_valid_o /
// out_stall_i); loads keep being taken while a result waits there, and a
// finished compute waits in its last step until that register is free.
// Configuration registers are on the APB port; a write to one outside a compute restarts the sweep.
// Reset empties the sample store, loads the default sweep and drops any result.
`default_nettype none
module nonuniform_dft_magnitude_sweep (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [3:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic signed [ndft_pkg::TIME_W-1:0]  sample_time_i,
  input  wire logic signed [ndft_pkg::VAL_W-1:0]   sample_value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [ndft_pkg::FREQ_W-1:0]              frequency_o,
  output logic [ndft_pkg::MAG_W-1:0]               magnitude_o,
  output logic                                     is_last_o,
  output logic                                     status_o
);

  ndft_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           cfg_wr;
  ndft_pkg::cmd_t cmd;
  ndft_pkg::sts_t sts;
  logic [ndft_pkg::FREQ_W-1:0] freq;
  logic [ndft_pkg::MAG_W-1:0]  mag;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // Register writes; an address beyond the list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    cfg_wr = 1'b0;
    if (wr_en) begin
      case (paddr[3:2])
        ndft_pkg::REG_START: begin
          cfg_d.start = pwdata;
          cfg_wr = 1'b1;
        end
        ndft_pkg::REG_STOP: begin
          cfg_d.stop = pwdata;
          cfg_wr = 1'b1;
        end
        ndft_pkg::REG_STEP: begin
          cfg_d.step = pwdata;
          cfg_wr = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start <= 32'd0;
      cfg_q.stop <= 32'd65536;
      cfg_q.step <= 32'd256;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register reads.
  always_comb begin
    case (paddr[3:2])
      ndft_pkg::REG_START: prdata = cfg_q.start;
      ndft_pkg::REG_STOP: prdata = cfg_q.stop;
      ndft_pkg::REG_STEP: prdata = cfg_q.step;
      default: prdata = '0;
    endcase
  end

  ndft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cfg_wr_i    (cfg_wr),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .freq_o      (freq),
    .mag_i       (mag),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frequency_o (frequency_o),
    .magnitude_o (magnitude_o),
    .is_last_o   (is_last_o),
    .status_o    (status_o)
  );

  ndft_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_time_i  (sample_time_i),
    .sample_value_i (sample_value_i),
    .freq_i         (freq),
    .magnitude_o    (mag)
  );

endmodule
`default_nettype wire
